// ===== src/hfc_pkg.sv =====
package hfc_pkg;

    localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
    localparam logic [7:0]  ADDR_BYTE   = 8'hA0;
    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_XOROUT  = 16'hFFFF;
    localparam logic [3:0]  COUNT_SAT   = 4'd9;
    localparam logic [3:0]  MIN_LEN_M1  = 4'd8;
    localparam logic [3:0]  CRC_START   = 4'd3;

    // Control from the input stage into the frame tracker
    typedef struct packed {
        logic fire;   // item leaves the input register this cycle
        logic last;   // item is the final byte of the payload
    } hfc_step_t;

    // Reflected CRC-16, one byte folded in LSB first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== src/hdlc_frame_fcs_checker.sv =====
// A last byte passes through two stages, the input register and the output register, before its verdict shows.
// Throughput: one byte per cycle while no verdict is stalled at the output; the byte-wide CRC fold sits in one stage.
// A last byte waits in the input register only while a verdict is stalled at the output.
// Bytes that are not last never wait on the output side.
// Reset (rst_n low, asynchronous): both stages empty, CRC at 0xFFFF, count and header
// state cleared; the block accepts items straight out of reset.
module hdlc_frame_fcs_checker
    import hfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       frame_match
);

    logic       s1_valid_reg;
    logic [7:0] s1_data_reg;
    logic       s1_last_reg;
    logic       out_valid_reg;
    logic       match_reg;
    logic       out_free;
    logic       advance;
    logic       in_take;
    logic       verdict;
    hfc_step_t  step;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign step.fire = advance;
    assign step.last = s1_last_reg;

    hfc_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (s1_data_reg),
        .verdict   (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance && s1_last_reg)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (advance && s1_last_reg)
            match_reg <= verdict;
    end

    assign out_valid   = out_valid_reg;
    assign frame_match = match_reg;

endmodule

// ===== src/hfc_track.sv =====
module hfc_track
    import hfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  hfc_step_t  step,
    input  logic [7:0] data_byte,
    output logic       verdict
);

    logic [3:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic        header_ok_reg, header_ok_next;
    logic [7:0]  delay0_reg, delay0_next;
    logic [7:0]  delay1_reg, delay1_next;
    logic [15:0] fcs;

    // FCS is sent low byte first, so the older byte is the low half
    assign fcs = {delay1_reg, delay0_reg};

    assign verdict = (count_reg >= MIN_LEN_M1) && header_ok_reg &&
                     (data_byte == FLAG_BYTE) && ((crc_reg ^ CRC_XOROUT) == fcs);

    always_comb
    begin
        count_next     = count_reg;
        crc_next       = crc_reg;
        header_ok_next = header_ok_reg;
        delay0_next    = delay0_reg;
        delay1_next    = delay1_reg;
        if (step.fire) begin
            if (step.last) begin
                // back to the idle frame state for the next payload
                count_next     = '0;
                crc_next       = CRC_INIT;
                header_ok_next = 1'b0;
                delay0_next    = '0;
                delay1_next    = '0;
            end else begin
                if (count_reg == 4'd0)
                    header_ok_next = (data_byte == FLAG_BYTE);
                else if (count_reg == 4'd1)
                    header_ok_next = header_ok_reg && (data_byte == ADDR_BYTE);

                // byte leaving the delay line is byte 1 or later
                if (count_reg >= CRC_START)
                    crc_next = crc_fold(crc_reg, delay0_reg);

                delay0_next = delay1_reg;
                delay1_next = data_byte;

                if (count_reg < COUNT_SAT)
                    count_next = count_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg     <= '0;
            crc_reg       <= CRC_INIT;
            header_ok_reg <= 1'b0;
            delay0_reg    <= '0;
            delay1_reg    <= '0;
        end else begin
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            header_ok_reg <= header_ok_next;
            delay0_reg    <= delay0_next;
            delay1_reg    <= delay1_next;
        end
    end

endmodule

// ===== src/hfc_checker.sv =====
module hfc_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       last_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       frame_match
);

    // stalled verdict holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_match))
        else $error("stalled verdict changed");

    // input side is only held back by a stalled verdict
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // a new verdict comes from a last byte that was taken and passed through the input register
    a_verdict_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && last_byte, 2))
        else $error("verdict without a matching last byte");

endmodule

bind hdlc_frame_fcs_checker hfc_checker u_hfc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_match (frame_match)
);

// ===== tb/sv/tb_hdlc_frame_fcs_checker.sv =====
module tb_hdlc_frame_fcs_checker;
    import hfc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_BYTES = 1600;
    localparam int LONG_HOLD = 250;

    typedef enum int {CLEAN, BAD_OPEN, BAD_ADDR, BAD_CLOSE, BAD_FCS, BAD_BODY, CUT_SHORT} flaw_t;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       drain;   // hold this byte until every verdict is in
    } tx_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       frame_match;

    tx_item_t tx_bytes[$];
    logic     verdicts_due[$];

    int total_bytes = 0;
    int bytes_taken = 0;
    int verdicts_pred = 0;
    int verdicts_seen = 0;
    int n_match = 0;
    int n_payloads = 0;
    int errors = 0;
    int cycles = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    // frame tracker state
    logic [3:0]  seen_cnt;
    logic [15:0] fcs_acc;
    logic        hdr_good;
    logic [7:0]  lag_old;
    logic [7:0]  lag_new;

    logic quiet;
    logic idle_on;
    assign quiet = bytes_taken >= total_bytes - 150;
    assign idle_on = !quiet && !bytes_taken[7];

    hdlc_frame_fcs_checker uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_match (frame_match)
    );

    always #5 clk = ~clk;

    // bit-serial form of the reflected X.25 update
    function automatic logic [15:0] x25_update(input logic [15:0] r, input logic [7:0] b);
        logic [15:0] t;
        t = r;
        for (int i = 0; i < 8; i++)
            t = (t[0] ^ b[i]) ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
        return t;
    endfunction

    task automatic clear_tracker();
        seen_cnt = '0;
        fcs_acc = CRC_INIT;
        hdr_good = 1'b0;
        lag_old = '0;
        lag_new = '0;
    endtask

    task automatic track_byte(input logic [7:0] b, input logic fin);
        logic ok;
        if (fin)
        begin
            ok = (seen_cnt >= MIN_LEN_M1) && hdr_good && (b == FLAG_BYTE)
                 && ((fcs_acc ^ CRC_XOROUT) == {lag_new, lag_old});
            verdicts_due.push_back(ok);
            verdicts_pred <= verdicts_pred + 1;
            clear_tracker();
        end
        else
        begin
            if (seen_cnt == 4'd0)
                hdr_good = (b == FLAG_BYTE);
            else if (seen_cnt == 4'd1)
                hdr_good = hdr_good && (b == ADDR_BYTE);
            // the two newest bytes are the FCS and stay out of the CRC
            if (seen_cnt >= CRC_START)
                fcs_acc = x25_update(fcs_acc, lag_old);
            lag_old = lag_new;
            lag_new = b;
            if (seen_cnt < COUNT_SAT)
                seen_cnt = seen_cnt + 4'd1;
        end
    endtask

    task automatic push_payload(input logic [7:0] bytes[$], input logic drain);
        for (int i = 0; i < bytes.size(); i++)
            tx_bytes.push_back('{data: bytes[i], fin: (i == bytes.size() - 1),
                                 drain: (i == 0) && drain});
        n_payloads++;
    endtask

    task automatic queue_frame(input int mid_len, input flaw_t flaw, input logic drain);
        logic [7:0]  fb[$];
        logic [15:0] acc;
        int          pos;
        fb.push_back(FLAG_BYTE);
        fb.push_back(ADDR_BYTE);
        for (int i = 0; i < mid_len; i++)
            fb.push_back(8'($urandom));
        acc = CRC_INIT;
        for (int i = 1; i < fb.size(); i++)
            acc = x25_update(acc, fb[i]);
        acc = acc ^ CRC_XOROUT;
        fb.push_back(acc[7:0]);
        fb.push_back(acc[15:8]);
        fb.push_back(FLAG_BYTE);
        case (flaw)
            BAD_OPEN:  fb[0] = fb[0] ^ 8'($urandom_range(1, 255));
            BAD_ADDR:  fb[1] = fb[1] ^ 8'($urandom_range(1, 255));
            BAD_CLOSE: fb[fb.size() - 1] = fb[fb.size() - 1] ^ 8'($urandom_range(1, 255));
            BAD_FCS:
            begin
                pos = fb.size() - $urandom_range(2, 3);
                fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
            BAD_BODY:
            begin
                // a single-bit error is always caught by the CRC
                pos = $urandom_range(1, fb.size() - 4);
                fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
            CUT_SHORT:
            begin
                pos = $urandom_range(1, fb.size() - 1);
                while (fb.size() > pos)
                    void'(fb.pop_back());
            end
            default: ;
        endcase
        push_payload(fb, drain);
    endtask

    task automatic queue_noise(input int len);
        logic [7:0] nb[$];
        for (int i = 0; i < len; i++)
            nb.push_back(8'($urandom));
        if ($urandom_range(0, 1))
            nb[0] = FLAG_BYTE;
        push_payload(nb, 1'b0);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : send_p
        logic     took_fin;
        tx_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= 8'h00;
            last_byte <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            took_fin = 1'b0;
            if (in_valid && !in_stall)
            begin
                track_byte(data_byte, last_byte);
                took_fin = last_byte;
                bytes_taken <= bytes_taken + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (tx_bytes.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (tx_bytes[0].drain && (verdicts_pred + took_fin != verdicts_seen))
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    nxt = tx_bytes.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= nxt.data;
                    last_byte <= nxt.fin;
                    if (idle_on && $urandom_range(0, 9) == 0)
                        gap_left <= $urandom_range(1, 6);
                end
            end
        end
    end

    // receiver and verdict check
    always @(posedge clk or negedge rst_n)
    begin : recv_p
        logic want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                verdicts_seen <= verdicts_seen + 1;
                if (frame_match === 1'b1)
                    n_match++;
                if (verdicts_due.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected verdict frame_match=%0b", frame_match);
                    errors++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (frame_match !== want)
                    begin
                        if (errors < 10)
                            $display("verdict %0d: frame_match expected %0b, got %0b",
                                     verdicts_seen, want, frame_match);
                        errors++;
                    end
                end
            end
            // one long hold so the block backs up into its input
            if (!hold_done && bytes_taken >= 500)
            begin
                hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
                out_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= (hold_left != 1);
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left <= $urandom_range(0, 5);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d verdicts outstanding", verdicts_due.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stim_p
        logic [7:0] pl[$];
        int         r;
        int         mid;
        clear_tracker();

        // lone last byte, then a minimum-length good frame
        pl = '{8'hFF};
        push_payload(pl, 1'b0);
        queue_frame(4, CLEAN, 1'b0);
        // one byte short, CRC still right
        queue_frame(3, CLEAN, 1'b0);
        pl = '{8'h00, FLAG_BYTE};
        push_payload(pl, 1'b0);

        queue_frame(6, CLEAN, 1'b1);
        while (tx_bytes.size() < RANDOM_BYTES + 20)
        begin
            r = $urandom_range(0, 99);
            mid = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(2, 12);
            if (r < 55)
                queue_frame(mid, CLEAN, $urandom_range(0, 14) == 0);
            else if (r < 88)
                queue_frame(mid, flaw_t'($urandom_range(1, 6)), 1'b0);
            else
                queue_noise($urandom_range(1, 20));
        end
        total_bytes = tx_bytes.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (bytes_taken == total_bytes && verdicts_pred == verdicts_seen);
        repeat (6) @(posedge clk);
        if (verdicts_due.size() != 0)
        begin
            $display("%0d verdicts never arrived", verdicts_due.size());
            errors += verdicts_due.size();
        end

        $display("%0d bytes in %0d payloads, %0d verdicts: %0d good frames, %0d rejected",
                 bytes_taken, n_payloads, verdicts_seen, n_match, verdicts_seen - n_match);
        $display("covered header, flag, FCS and body errors, short and cut payloads, noise");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
